[design/mep_pkg.sv]
// Shared constants, types and helper functions for the Mandelbrot escape-time pixel core.
package mep_pkg;

  localparam int DIM_W     = 13;
  localparam int PIX_W     = 12;
  localparam int ITER_W    = 9;
  localparam int COLOR_W   = 8;
  localparam int FRAC_BITS = 28;
  localparam int FX_W      = 32;
  localparam int MAX_DIM   = 4096;
  localparam int MAX_ITER  = 256;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_W  = PIX_W + FRAC_BITS + 1;
  localparam int PROD_W = 2 * FX_W;
  localparam int SQ_W   = PROD_W - FRAC_BITS;
  localparam int CR_W   = PROD_W - FRAC_BITS + 1;

  localparam logic signed [PROD_W-1:0] SAT_HI = {{(PROD_W-FX_W+1){1'b0}}, {(FX_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO = {{(PROD_W-FX_W+1){1'b1}}, {(FX_W-1){1'b0}}};

  typedef logic signed [FX_W-1:0] fx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_MAX_ITER     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    fx_t               cx;
    fx_t               cy;
    logic [ITER_W-1:0] lim;
  } job_t;

  function automatic fx_t sat_fx(input logic signed [PROD_W-1:0] v);
    fx_t r;
    if (v > SAT_HI) begin
      r = FX_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = FX_W'(SAT_LO);
    end else begin
      r = FX_W'(v);
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic logic [ITER_W-1:0] clamp_iter(input logic [ITER_W-1:0] n);
    logic [ITER_W-1:0] r;
    if (n > ITER_W'(MAX_ITER)) begin
      r = ITER_W'(MAX_ITER);
    end else begin
      r = n;
    end
    return r;
  endfunction

endpackage

[design/mep_in_if.sv]
// Request channel carrying one pixel coordinate.
interface mep_in_if import mep_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source(output valid, pixel_x, pixel_y, input ready);
  modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

[design/mep_out_if.sv]
// Result channel carrying one pixel color.
interface mep_out_if import mep_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green_blue;
  logic               escaped;
  logic [COLOR_W-1:0] escape_iteration;

  modport source(output valid, red, green_blue, escaped, escape_iteration, input ready);
  modport sink(input valid, red, green_blue, escaped, escape_iteration, output ready);
endinterface

[design/mandelbrot_escape_pixel_core.sv]
// Top level of the Mandelbrot escape-time pixel core.
//
//   channel  direction  handshake         payload
//   in_if    sink       valid / ready     pixel_x, pixel_y
//   out_if   source     valid / ready     red, green_blue, escaped, escape_iteration
//   cfg_*    write      cfg_we            cfg_idx, cfg_data
//
// The front end takes a new request only once its last job has gone to the queue: it
// accepts the request, runs its two bit-serial coordinate dividers to the end and then
// hands the job to the queue. Each iteration of the engine is a multiply state on its
// three 32x32 multipliers and a check state, and an escaped pixel then runs a bit-serial
// color divide; the engine takes no new job until its result is in the output register.
// Reset is synchronous and clears all control state; the two-entry queue and the
// output register let either side stall while the other keeps working.
module mandelbrot_escape_pixel_core import mep_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  mep_in_if.sink               in_if,
  mep_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic [DIM_W-1:0]  width_r, height_r;
  logic [ITER_W-1:0] max_iter_r;
  job_t              f_job, q_job;
  logic              f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= DIM_W'(640);
      height_r   <= DIM_W'(480);
      max_iter_r <= ITER_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IMAGE_WIDTH:  width_r    <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r   <= cfg_data;
        CFG_MAX_ITER:     max_iter_r <= cfg_data[ITER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .width     (width_r),
    .height    (height_r),
    .max_iter  (max_iter_r),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  mep_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (f_job),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (q_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  mep_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (q_job),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .out_if    (out_if)
  );

endmodule

[design/mep_front.sv]
// Front end: accepts a pixel and maps it to c with two bit-serial dividers.
module mep_front import mep_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mep_in_if.sink            in_if,
  input  logic [DIM_W-1:0]  width,
  input  logic [DIM_W-1:0]  height,
  input  logic [ITER_W-1:0] max_iter,
  output job_t              job,
  output logic              job_valid,
  input  logic              job_ready
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int DW    = NUM_W + 2;
  localparam logic signed [DW-1:0] OFS_X = DW'(1) << (FRAC_BITS + 1);
  localparam logic signed [DW-1:0] OFS_Y = DW'(1) << FRAC_BITS;

  logic              busy_r, done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [NUM_W-1:0]  numx_r, numy_r, qx_r, qy_r;
  logic [DIM_W:0]    remx_r, remy_r;
  logic [DIM_W-1:0]  dx_r, dy_r;
  logic [ITER_W-1:0] lim_r;
  logic [DIM_W:0]    shx, shy;
  logic              bitx, bity;
  logic signed [DW-1:0] diffx, diffy;

  assign in_if.ready = !busy_r && !done_r;
  assign job_valid   = done_r;

  assign shx  = {remx_r[DIM_W-1:0], numx_r[NUM_W-1]};
  assign shy  = {remy_r[DIM_W-1:0], numy_r[NUM_W-1]};
  assign bitx = shx >= {1'b0, dx_r};
  assign bity = shy >= {1'b0, dy_r};

  assign diffx   = $signed({2'b00, qx_r}) - OFS_X;
  assign diffy   = $signed({2'b00, qy_r}) - OFS_Y;
  assign job.cx  = sat_fx(PROD_W'(diffx));
  assign job.cy  = sat_fx(PROD_W'(diffy));
  assign job.lim = lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (done_r && job_ready) begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      numx_r <= {in_if.pixel_x, {(FRAC_BITS + 1){1'b0}}};
      numy_r <= {in_if.pixel_y, {(FRAC_BITS + 1){1'b0}}};
      remx_r <= '0;
      remy_r <= '0;
      qx_r   <= '0;
      qy_r   <= '0;
      dx_r   <= clamp_dim(width);
      dy_r   <= clamp_dim(height);
      lim_r  <= clamp_iter(max_iter);
    end else if (busy_r) begin
      numx_r <= {numx_r[NUM_W-2:0], 1'b0};
      numy_r <= {numy_r[NUM_W-2:0], 1'b0};
      remx_r <= bitx ? shx - {1'b0, dx_r} : shx;
      remy_r <= bity ? shy - {1'b0, dy_r} : shy;
      qx_r   <= {qx_r[NUM_W-2:0], bitx};
      qy_r   <= {qy_r[NUM_W-2:0], bity};
    end
  end

endmodule

[design/mep_queue.sv]
// Two-entry queue between the front end and the iteration engine.
module mep_queue import mep_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  job_t wr_data,
  input  logic wr_valid,
  output logic wr_ready,
  output job_t rd_data,
  output logic rd_valid,
  input  logic rd_ready
);

  job_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

[design/mep_back.sv]
// Back end: iterates z = z^2 + c, scales the escape step and holds the result.
module mep_back import mep_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  job_t   job,
  input  logic   job_valid,
  output logic   job_ready,
  mep_out_if.source out_if
);

  localparam int ZW    = SQ_W + 2;
  localparam int DIV_N = 2 * COLOR_W;
  localparam int DCW   = $clog2(DIV_N);
  localparam logic [SQ_W:0] FOUR = (SQ_W + 1)'(4) << FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_CHK  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  fx_t                 cx_r, cy_r, zx_r, zy_r;
  logic [ITER_W-1:0]   lim_r, k_r;
  logic [SQ_W-1:0]     sx_r, sy_r;
  logic signed [CR_W-1:0] cr_r;
  logic signed [PROD_W-1:0] pxx, pyy, pxy;
  logic signed [ZW-1:0] zx_sum, zy_sum;
  logic [SQ_W:0]       mag;
  logic                esc_hit, esc_r;
  logic [COLOR_W-1:0]  eit_r, q_r;
  logic [DIV_N-1:0]    num_r;
  logic [ITER_W:0]     rem_r, rem_sh;
  logic                qbit;
  logic [DCW-1:0]      dcnt_r;
  logic                out_valid_r;
  logic [COLOR_W-1:0]  red_r, gb_r, it_r;
  logic                escd_r;
  logic                out_free;

  assign job_ready = state_r == S_IDLE;
  assign out_free  = !out_valid_r || out_if.ready;

  assign pxx    = zx_r * zx_r;
  assign pyy    = zy_r * zy_r;
  assign pxy    = zx_r * zy_r;
  assign zx_sum = $signed({2'b00, sx_r}) - $signed({2'b00, sy_r}) + ZW'(cx_r);
  assign zy_sum = ZW'(cr_r) + ZW'(cy_r);
  assign mag    = {1'b0, sx_r} + {1'b0, sy_r};
  assign esc_hit = (k_r != '0) && (mag > FOUR);

  assign rem_sh = {rem_r[ITER_W-1:0], num_r[DIV_N-1]};
  assign qbit   = rem_sh >= {1'b0, lim_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (job_valid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_CHK;
      S_CHK: begin
        if (esc_hit) begin
          state_nxt = S_DIV;
        end else if (k_r == lim_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_DIV:  if (dcnt_r == DCW'(DIV_N - 1)) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        cx_r  <= job.cx;
        cy_r  <= job.cy;
        lim_r <= job.lim;
        zx_r  <= '0;
        zy_r  <= '0;
        k_r   <= '0;
        esc_r <= 1'b0;
      end
      S_MUL: begin
        sx_r <= pxx[PROD_W-1:FRAC_BITS];
        sy_r <= pyy[PROD_W-1:FRAC_BITS];
        cr_r <= pxy[PROD_W-1:FRAC_BITS-1];
      end
      S_CHK: begin
        if (esc_hit) begin
          esc_r  <= 1'b1;
          eit_r  <= COLOR_W'(k_r - ITER_W'(1));
          num_r  <= DIV_N'(COLOR_W'(k_r - ITER_W'(1))) * DIV_N'(255);
          rem_r  <= '0;
          q_r    <= '0;
          dcnt_r <= '0;
        end else if (k_r != lim_r) begin
          zx_r <= sat_fx(PROD_W'(zx_sum));
          zy_r <= sat_fx(PROD_W'(zy_sum));
          k_r  <= k_r + ITER_W'(1);
        end
      end
      S_DIV: begin
        num_r  <= {num_r[DIV_N-2:0], 1'b0};
        rem_r  <= qbit ? rem_sh - {1'b0, lim_r} : rem_sh;
        q_r    <= {q_r[COLOR_W-2:0], qbit};
        dcnt_r <= dcnt_r + DCW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          red_r  <= esc_r ? q_r : '1;
          gb_r   <= esc_r ? '0 : '1;
          escd_r <= esc_r;
          it_r   <= esc_r ? eit_r : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.red              = red_r;
  assign out_if.green_blue       = gb_r;
  assign out_if.escaped          = escd_r;
  assign out_if.escape_iteration = it_r;

endmodule

[design/mep_checker.sv]
// Port-level checks on the result channel of the pixel core, with their bind.
module mep_checker import mep_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COLOR_W-1:0] red,
  input logic [COLOR_W-1:0] green_blue,
  input logic               escaped,
  input logic [COLOR_W-1:0] escape_iteration
);

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_inside_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !escaped |-> red == '1 && green_blue == '1 && escape_iteration == '0)
    else $error("inside pixel is not white");

  a_escaped_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && escaped |-> green_blue == '0 && red <= escape_iteration * 255)
    else $error("escaped pixel color is inconsistent");

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind mandelbrot_escape_pixel_core mep_checker u_mep_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .red              (out_if.red),
  .green_blue       (out_if.green_blue),
  .escaped          (out_if.escaped),
  .escape_iteration (out_if.escape_iteration)
);

[sim/testbench.sv]
// Self-checking testbench for the Mandelbrot escape-time pixel core.
`timescale 1ns / 100ps

module testbench;
  import mep_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam longint FX_ONE = 64'sd1 <<< FRAC_BITS;
  localparam longint FX_HI = 8 * FX_ONE - 1;
  localparam longint FX_LO = -8 * FX_ONE;
  localparam int DRAIN_CYCLES = 600;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 1500;

  typedef struct {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pixel_t;

  typedef struct {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green_blue;
    logic               escaped;
    logic [COLOR_W-1:0] escape_iteration;
  } color_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DIM_W-1:0] cfg_data;

  mep_in_if in_ch();
  mep_out_if out_ch();

  mandelbrot_escape_pixel_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  pixel_t pending_pixels[$];
  color_t expected_colors[$];
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [ITER_W-1:0] iter_reg;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;
  int error_count;
  int quiet_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint sat_q4(longint v);
    if (v > FX_HI) begin
      return FX_HI;
    end
    if (v < FX_LO) begin
      return FX_LO;
    end
    return v;
  endfunction

  function automatic longint clamp_size(logic [DIM_W-1:0] d);
    if (d == 0) begin
      return 1;
    end
    if (d > MAX_DIM) begin
      return MAX_DIM;
    end
    return d;
  endfunction

  function automatic color_t predict_color(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    longint w, h, lim, cx, cy, zx, zy, sx, sy, cr, mag, esc_it;
    logic esc;
    color_t c;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    lim = (iter_reg > MAX_ITER) ? MAX_ITER : iter_reg;
    cx = sat_q4((2 * longint'(px) * FX_ONE) / w - 2 * FX_ONE);
    cy = sat_q4((2 * longint'(py) * FX_ONE) / h - FX_ONE);
    zx = 0;
    zy = 0;
    esc = 1'b0;
    esc_it = 0;
    for (longint it = 0; it < lim; it++) begin
      sx = (zx * zx) >>> FRAC_BITS;
      sy = (zy * zy) >>> FRAC_BITS;
      cr = (zx * zy) >>> (FRAC_BITS - 1);
      zx = sat_q4(sx - sy + cx);
      zy = sat_q4(cr + cy);
      mag = ((zx * zx) >>> FRAC_BITS) + ((zy * zy) >>> FRAC_BITS);
      if (mag > 4 * FX_ONE) begin
        esc = 1'b1;
        esc_it = it;
        break;
      end
    end
    if (esc) begin
      c.red = COLOR_W'((esc_it * 255) / lim);
      c.green_blue = '0;
      c.escaped = 1'b1;
      c.escape_iteration = COLOR_W'(esc_it);
    end else begin
      c.red = 8'd255;
      c.green_blue = 8'd255;
      c.escaped = 1'b0;
      c.escape_iteration = '0;
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_colors.push_back(predict_color(in_ch.pixel_x, in_ch.pixel_y));
      end
      if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.pixel_x <= pending_pixels[0].x;
        in_ch.pixel_y <= pending_pixels[0].y;
        pending_pixels.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    color_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: result with no request outstanding", $realtime);
          error_count++;
        end else begin
          want = expected_colors.pop_front();
          if (out_ch.red !== want.red) begin
            report_mismatch("red", out_ch.red, want.red);
          end
          if (out_ch.green_blue !== want.green_blue) begin
            report_mismatch("green_blue", out_ch.green_blue, want.green_blue);
          end
          if (out_ch.escaped !== want.escaped) begin
            report_mismatch("escaped", out_ch.escaped, want.escaped);
          end
          if (out_ch.escape_iteration !== want.escape_iteration) begin
            report_mismatch("escape_iteration", out_ch.escape_iteration,
                            want.escape_iteration);
          end
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = value;
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      height_reg = value;
    end else if (idx == CFG_MAX_ITER) begin
      iter_reg = ITER_W'(value);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pixels.size() > 0 || in_ch.valid || expected_colors.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_pixel(int x, int y);
    pixel_t p;
    p.x = PIX_W'(x);
    p.y = PIX_W'(y);
    pending_pixels.push_back(p);
  endtask

  task automatic add_random_pixels(int count);
    int w, h;
    w = int'(clamp_size(width_reg));
    h = int'(clamp_size(height_reg));
    if (w > 4096) w = 4096;
    if (h > 4096) h = 4096;
    repeat (count) begin
      if ($urandom_range(99) < 85) begin
        add_pixel($urandom_range(w - 1), $urandom_range(h - 1));
      end else begin
        add_pixel($urandom_range(4095), $urandom_range(4095));
      end
    end
  endtask

  initial begin
    int sizes[4];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_IMAGE_WIDTH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.pixel_x = '0;
    in_ch.pixel_y = '0;
    out_ch.ready = 1'b0;
    width_reg = 13'd640;
    height_reg = 13'd480;
    iter_reg = 9'd64;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    error_count = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(320, 240);
    add_pixel(160, 240);
    add_pixel(480, 240);
    add_pixel(639, 479);
    add_pixel(640, 0);
    add_pixel(0, 4095);
    add_pixel(4095, 0);
    drain();

    write_reg(CFG_IMAGE_WIDTH, 13'd0);
    write_reg(CFG_IMAGE_HEIGHT, 13'd8191);
    write_reg(CFG_MAX_ITER, 13'd0);
    write_reg(CFG_UNUSED_IDX, 13'h1fff);
    add_pixel(0, 4095);
    add_pixel(1, 2048);
    add_pixel(0, 0);
    drain();

    write_reg(CFG_IMAGE_WIDTH, 13'd4096);
    write_reg(CFG_IMAGE_HEIGHT, 13'd1);
    write_reg(CFG_MAX_ITER, 13'd511);
    add_pixel(2048, 0);
    add_pixel(1500, 0);
    add_pixel(4095, 1);
    drain();
    write_reg(CFG_MAX_ITER, 13'd1);
    add_pixel(0, 0);
    add_pixel(2048, 0);
    add_pixel(4095, 4095);
    drain();
    write_reg(CFG_MAX_ITER, 13'd256);
    add_pixel(1024, 0);
    add_pixel(2600, 0);
    add_pixel(1000, 0);
    drain();

    sizes = '{1, 64, 640, 4096};
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_IMAGE_WIDTH, (phase == 5) ? 13'd8191 : DIM_W'($urandom_range(1, 4096)));
      write_reg(CFG_IMAGE_HEIGHT, DIM_W'(sizes[phase % 4]));
      write_reg(CFG_MAX_ITER, (phase == 7) ? 13'd256 : DIM_W'($urandom_range(1, 48)));
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 88; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 88; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (phase == 4) begin
        hold_request = HOLD_OFF_CYCLES;
      end
      add_random_pixels((phase == 7) ? 40 : 190);
      drain();
    end

    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
